[design/secu_pkg.sv]
package secu_pkg;

  localparam int unsigned KEYWORD_LETTERS = 15;
  localparam int unsigned NUM_KEYWORDS = 5;
  localparam int unsigned KW_MAX_LEN = 6;
  localparam int unsigned COMP_MAX_LEN = 5;

  localparam logic [5:0] NAME_LIMIT_RESET = 6'd31;
  localparam logic [4:0] CAND_ALL = 5'h1F;

  typedef enum logic [2:0] {
    PH_LEAD      = 3'd0,
    PH_KEYWORD   = 3'd1,
    PH_GAP1      = 3'd2,
    PH_COMPANION = 3'd3,
    PH_GAP2      = 3'd4,
    PH_NAME      = 3'd5,
    PH_DONE      = 3'd6
  } phase_t;

  typedef struct packed {
    logic       terminator;
    logic [7:0] ch;
  } in_item_t;

  typedef struct packed {
    logic [2:0] event_res;
    logic       matched;
    logic       finished;
    logic       char_valid;
    logic [7:0] name_char;
  } out_item_t;

  // event codes follow the row order: insert, update, delete, create, drop
  localparam logic [7:0] KW_TEXT [NUM_KEYWORDS][KW_MAX_LEN] = '{
    '{"i", "n", "s", "e", "r", "t"},
    '{"u", "p", "d", "a", "t", "e"},
    '{"d", "e", "l", "e", "t", "e"},
    '{"c", "r", "e", "a", "t", "e"},
    '{"d", "r", "o", "p", 8'h00, 8'h00}
  };
  localparam logic [3:0] KW_LEN [NUM_KEYWORDS] = '{4'd6, 4'd6, 4'd6, 4'd6, 4'd4};

  localparam logic [7:0] COMP_TEXT [NUM_KEYWORDS][COMP_MAX_LEN] = '{
    '{"i", "n", "t", "o", 8'h00},
    '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"f", "r", "o", "m", 8'h00},
    '{"t", "a", "b", "l", "e"},
    '{"t", "a", "b", "l", "e"}
  };
  localparam logic [2:0] COMP_LEN [NUM_KEYWORDS] = '{3'd4, 3'd0, 3'd4, 3'd5, 3'd5};

  function automatic logic is_ws(logic [7:0] c);
    return (c == 8'd32) || (c == 8'd9) || (c == 8'd10) || (c == 8'd13);
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return ((c >= 8'd97) && (c <= 8'd122)) || ((c >= 8'd65) && (c <= 8'd90));
  endfunction

  function automatic logic is_ident(logic [7:0] c);
    return is_alpha(c) || ((c >= 8'd48) && (c <= 8'd57)) || (c == 8'd95);
  endfunction

  function automatic logic [7:0] to_lower(logic [7:0] c);
    return ((c >= 8'd65) && (c <= 8'd90)) ? c + 8'd32 : c;
  endfunction

  function automatic logic [3:0] kw_len(logic [2:0] i);
    return (i < 3'(NUM_KEYWORDS)) ? KW_LEN[i] : 4'd0;
  endfunction

  function automatic logic [7:0] kw_char(logic [2:0] i, logic [3:0] pos);
    if ((i < 3'(NUM_KEYWORDS)) && (pos < 4'(KW_MAX_LEN))) begin
      return KW_TEXT[i][pos[2:0]];
    end
    return 8'h00;
  endfunction

  // event code folded into the five rows
  function automatic logic [2:0] ev_row(logic [2:0] ev);
    return (ev >= 3'(NUM_KEYWORDS)) ? ev - 3'(NUM_KEYWORDS) : ev;
  endfunction

  function automatic logic [2:0] comp_len(logic [2:0] ev);
    return COMP_LEN[ev_row(ev)];
  endfunction

  function automatic logic [7:0] comp_char(logic [2:0] ev, logic [2:0] pos);
    if (pos < 3'(COMP_MAX_LEN)) begin
      return COMP_TEXT[ev_row(ev)][pos];
    end
    return 8'h00;
  endfunction

endpackage

[design/secu_in_reg.sv]
module secu_in_reg (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  secu_pkg::in_item_t  in_item,
  output logic                item_valid,
  output secu_pkg::in_item_t  item,
  input  logic                advance
);

  logic               held;
  secu_pkg::in_item_t data;

  assign in_ready   = !held || advance;
  assign item_valid = held;
  assign item       = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_valid && in_ready) begin
      held <= 1'b1;
    end else if (advance) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data <= in_item;
    end
  end

endmodule

[design/secu_core.sv]
module secu_core #(
  parameter int unsigned KEYWORD_LETTERS = secu_pkg::KEYWORD_LETTERS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  input  logic [5:0]          cfg_data,
  input  logic                item_valid,
  input  secu_pkg::in_item_t  item,
  input  logic                out_free,
  output logic                advance,
  output logic                res_valid,
  output secu_pkg::out_item_t res
);

  secu_pkg::phase_t phase, phase_next;
  logic [4:0] cand, cand_next;
  logic [3:0] letter_count, letter_count_next;
  logic [2:0] event_code, event_code_next;
  logic [2:0] comp_pos, comp_pos_next;
  logic [5:0] name_count, name_count_next;
  logic [5:0] name_limit;

  // first surviving keyword whose length equals the letters read
  function automatic logic [3:0] decide(logic [4:0] c, logic [3:0] n);
    for (int i = 0; i < int'(secu_pkg::NUM_KEYWORDS); i++) begin
      if (c[i] && (secu_pkg::kw_len(3'(i)) == n)) begin
        return {1'b1, 3'(i)};
      end
    end
    return 4'd0;
  endfunction

  always_comb begin
    logic       more;
    logic       vd;
    logic       vd_ok;
    logic [3:0] dk;
    logic [7:0] c;
    logic [7:0] lch;
    logic       t;

    c     = item.ch;
    t     = item.terminator;
    lch   = secu_pkg::to_lower(c);
    more  = 1'b1;
    vd    = 1'b0;
    vd_ok = 1'b0;
    dk    = 4'd0;
    res   = '0;
    res_valid = 1'b0;

    phase_next        = phase;
    cand_next         = cand;
    letter_count_next = letter_count;
    event_code_next   = event_code;
    comp_pos_next     = comp_pos;
    name_count_next   = name_count;

    // phases run in order; one byte may fall through several of them
    if (phase_next == secu_pkg::PH_LEAD) begin
      if (!t && secu_pkg::is_ws(c)) begin
        more = 1'b0;
      end else begin
        phase_next        = secu_pkg::PH_KEYWORD;
        cand_next         = secu_pkg::CAND_ALL;
        letter_count_next = 4'd0;
      end
    end

    if (more && phase_next == secu_pkg::PH_KEYWORD) begin
      if (!t && secu_pkg::is_alpha(c)) begin
        more = 1'b0;
        for (int i = 0; i < int'(secu_pkg::NUM_KEYWORDS); i++) begin
          if ((letter_count_next >= secu_pkg::kw_len(3'(i))) ||
              (secu_pkg::kw_char(3'(i), letter_count_next) != lch)) begin
            cand_next[i] = 1'b0;
          end
        end
        letter_count_next = letter_count_next + 4'd1;
        if (letter_count_next >= 4'(KEYWORD_LETTERS)) begin
          dk = decide(cand_next, letter_count_next);
          if (!dk[3]) begin
            vd = 1'b1;
          end else begin
            event_code_next = dk[2:0];
            phase_next      = secu_pkg::PH_GAP1;
          end
        end
      end else begin
        dk = decide(cand_next, letter_count_next);
        if (!dk[3]) begin
          vd   = 1'b1;
          more = 1'b0;
        end else begin
          event_code_next = dk[2:0];
          phase_next      = secu_pkg::PH_GAP1;
        end
      end
    end

    if (more && phase_next == secu_pkg::PH_GAP1) begin
      if (!t && secu_pkg::is_ws(c)) begin
        more = 1'b0;
      end else begin
        comp_pos_next   = 3'd0;
        name_count_next = 6'd0;
        phase_next = (secu_pkg::comp_len(event_code_next) == 3'd0) ?
                     secu_pkg::PH_NAME : secu_pkg::PH_COMPANION;
      end
    end

    if (more && phase_next == secu_pkg::PH_COMPANION) begin
      more = 1'b0;
      if (t || (comp_pos_next >= secu_pkg::comp_len(event_code_next)) ||
          (lch != secu_pkg::comp_char(event_code_next, comp_pos_next))) begin
        vd = 1'b1;
      end else begin
        comp_pos_next = comp_pos_next + 3'd1;
        if (comp_pos_next >= secu_pkg::comp_len(event_code_next)) begin
          phase_next = secu_pkg::PH_GAP2;
        end
      end
    end

    if (more && phase_next == secu_pkg::PH_GAP2) begin
      if (!t && secu_pkg::is_ws(c)) begin
        more = 1'b0;
      end else begin
        phase_next = secu_pkg::PH_NAME;
      end
    end

    if (more && phase_next == secu_pkg::PH_NAME) begin
      if (!t && secu_pkg::is_ident(c) && (name_count_next < name_limit)) begin
        res_valid      = 1'b1;
        res.name_char  = c;
        res.char_valid = 1'b1;
        res.event_res  = event_code_next;
        name_count_next = name_count_next + 6'd1;
      end else begin
        vd    = 1'b1;
        vd_ok = (name_count_next != 6'd0);
      end
    end

    if (vd) begin
      res_valid     = 1'b1;
      res.finished  = 1'b1;
      res.matched   = vd_ok;
      res.event_res = vd_ok ? event_code_next : 3'd0;
      phase_next    = secu_pkg::PH_DONE;
    end

    if (t) begin
      phase_next        = secu_pkg::PH_LEAD;
      cand_next         = secu_pkg::CAND_ALL;
      letter_count_next = 4'd0;
      event_code_next   = 3'd0;
      comp_pos_next     = 3'd0;
      name_count_next   = 6'd0;
    end
  end

  assign advance = item_valid && (out_free || !res_valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= secu_pkg::PH_LEAD;
      cand         <= secu_pkg::CAND_ALL;
      letter_count <= 4'd0;
      event_code   <= 3'd0;
      comp_pos     <= 3'd0;
      name_count   <= 6'd0;
    end else if (advance) begin
      phase        <= phase_next;
      cand         <= cand_next;
      letter_count <= letter_count_next;
      event_code   <= event_code_next;
      comp_pos     <= comp_pos_next;
      name_count   <= name_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      name_limit <= secu_pkg::NAME_LIMIT_RESET;
    end else if (cfg_valid) begin
      name_limit <= cfg_data;
    end
  end

endmodule

[design/secu_out_reg.sv]
module secu_out_reg (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  secu_pkg::out_item_t res,
  output logic                out_free,
  output logic                out_valid,
  input  logic                out_ready,
  output secu_pkg::out_item_t out_item
);

  logic                held;
  secu_pkg::out_item_t data;

  assign out_free  = !held || out_ready;
  assign out_valid = held;
  assign out_item  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (load) begin
      held <= 1'b1;
    end else if (out_ready) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= res;
    end
  end

endmodule

[design/sql_statement_event_classifier_unit.sv]
// SQL statement event classifier.
// Slave stream: one statement byte per request in s_tdata; s_tlast marks the
// terminator request (its byte is ignored) and returns the parser to its start.
// Master stream: at most one result per input request. A name character comes
// with m_tuser high; the verdict comes with m_tlast high, m_tdata[8] set when
// the statement was recognised with a nonempty table name.
// Configuration: cfg_data sets the table-name length limit (reset 31); it is
// always accepted and should be written only while the block is idle.
// Timing: a request is held in the input register on acceptance; its result,
// if any, is formed combinationally and loaded into the output register when
// it is free, raising m_tvalid. One request can be taken every cycle while
// results flow; the per-byte parser state update is the loop that sets it.
// Reset: clears the parser to its start state, drops both valid flags and
// restores the name limit. When the receiver stalls, the result register holds
// and the input register fills; s_tready then falls until a result is taken,
// except that requests that produce no result keep flowing.
module sql_statement_event_classifier_unit #(
  parameter int unsigned KEYWORD_LETTERS = secu_pkg::KEYWORD_LETTERS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] ch
  input  logic        s_tlast,   // terminator
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] name_char, [8] matched, [11:9] event_res, rest 0
  output logic        m_tlast,   // finished
  output logic        m_tuser,   // char_valid
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [5:0]  cfg_data
);

  secu_pkg::in_item_t  in_item;
  secu_pkg::in_item_t  item;
  secu_pkg::out_item_t res;
  secu_pkg::out_item_t out_item;
  logic item_valid;
  logic advance;
  logic res_valid;
  logic out_free;

  assign in_item.ch         = s_tdata;
  assign in_item.terminator = s_tlast;
  assign cfg_ready          = 1'b1;

  secu_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_item    (in_item),
    .item_valid (item_valid),
    .item       (item),
    .advance    (advance)
  );

  secu_core #(
    .KEYWORD_LETTERS (KEYWORD_LETTERS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .item_valid (item_valid),
    .item       (item),
    .out_free   (out_free),
    .advance    (advance),
    .res_valid  (res_valid),
    .res        (res)
  );

  secu_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (advance && res_valid),
    .res       (res),
    .out_free  (out_free),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_item  (out_item)
  );

  assign m_tdata = {4'd0, out_item.event_res, out_item.matched, out_item.name_char};
  assign m_tlast = out_item.finished;
  assign m_tuser = out_item.char_valid;

endmodule
